/* design/sakd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sakd_pkg;

	localparam int NUM_KEYPOINTS = 17;
	localparam int MAX_BINS      = 1024;

	localparam int BIN_W    = $clog2(MAX_BINS);
	localparam int KP_W     = 5;
	localparam int VAL_W    = 8;
	localparam int ZP_W     = 8;
	localparam int SCALE_W  = 16;
	localparam int COORD_W  = 9;
	localparam int SCORE_W  = 25;
	localparam int DIFF_W   = VAL_W + 1;
	localparam int PROD_W   = DIFF_W + SCALE_W + 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(MAX_BINS - 1);
	localparam logic [KP_W-1:0]  KP_LAST  = KP_W'(NUM_KEYPOINTS - 1);
	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ZERO_POINT_X = 2'd0,
		CFG_ZERO_POINT_Y = 2'd1,
		CFG_SCALE_X      = 2'd2,
		CFG_SCALE_Y      = 2'd3
	} cfg_idx_t;

	// Per-keypoint argmax result handed from the row tracker to the score pipe
	typedef struct packed {
		logic [KP_W-1:0]         kp;
		logic                    last;
		logic signed [VAL_W-1:0] val_x;
		logic [BIN_W-1:0]        idx_x;
		logic signed [VAL_W-1:0] val_y;
		logic [BIN_W-1:0]        idx_y;
	} kp_res_t;

endpackage

`default_nettype wire

/* design/sakd_row_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none

module sakd_row_tracker
	import sakd_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    accept,
	input  wire logic                    cmd,
	input  wire logic signed [VAL_W-1:0] sample,
	input  wire logic                    row_end,
	output logic                         emit,
	output kp_res_t                      res
);

	logic                    started_q;
	logic [BIN_W-1:0]        bin_q;
	logic [KP_W-1:0]         kp_q;
	logic signed [VAL_W-1:0] best_x_q, best_y_q;
	logic [BIN_W-1:0]        idx_x_q, idx_y_q;

	logic                    start;
	logic [BIN_W-1:0]        bin;
	logic signed [VAL_W-1:0] vx, vy;
	logic [BIN_W-1:0]        ix, iy;

	always_comb begin
		start = !started_q;
		bin   = start ? '0 : bin_q;
		vx    = (start && !cmd) ? VAL_MIN : best_x_q;
		ix    = (start && !cmd) ? '0 : idx_x_q;
		vy    = (start && cmd) ? VAL_MIN : best_y_q;
		iy    = (start && cmd) ? '0 : idx_y_q;
		// strictly greater: ties keep the first bin
		if (!cmd && (sample > vx)) begin
			vx = sample;
			ix = bin;
		end
		if (cmd && (sample > vy)) begin
			vy = sample;
			iy = bin;
		end
	end

	assign emit = cmd && row_end;

	always_comb begin
		res.kp    = kp_q;
		res.last  = (kp_q == KP_LAST);
		res.val_x = vx;
		res.idx_x = ix;
		res.val_y = vy;
		res.idx_y = iy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			bin_q     <= '0;
			kp_q      <= '0;
			best_x_q  <= VAL_MIN;
			best_y_q  <= VAL_MIN;
			idx_x_q   <= '0;
			idx_y_q   <= '0;
		end else if (accept) begin
			started_q <= !row_end;
			if (row_end) begin
				bin_q <= '0;
			end else if (bin != BIN_LAST) begin
				bin_q <= bin + 1'b1;
			end else begin
				bin_q <= bin;
			end
			if (emit) begin
				best_x_q <= VAL_MIN;
				best_y_q <= VAL_MIN;
				idx_x_q  <= '0;
				idx_y_q  <= '0;
				kp_q     <= (kp_q == KP_LAST) ? '0 : kp_q + 1'b1;
			end else begin
				best_x_q <= vx;
				best_y_q <= vy;
				idx_x_q  <= ix;
				idx_y_q  <= iy;
			end
		end
	end

endmodule

`default_nettype wire

/* design/simcc_keypoint_argmax_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Argmax decoder for SimCC keypoint classifier rows.
// Input channel (in_valid / in_stall): one int8 bin per beat; for each
// keypoint first its x row (cmd = 0), then its y row (cmd = 1), row_end high
// on the last bin of each row. One beat is taken per cycle while in_stall is low.
// Output channel (out_valid / out_stall): one beat per keypoint, sent when
// its y row ends: keypoint number, both argmax bins halved, and the larger
// of the two dequantized maxima in signed Q.8. last_keypoint marks the
// final keypoint of a pose.
// Path: the closing y beat's result is loaded into the argmax register
// at the edge that takes that beat, then moves to the multiply register,
// then to the output register. Throughput: one input beat per cycle while
// in_stall is low, as the compare-and-keep step is combinational.
// Reset clears all row state, the keypoint count and the pipe; zero points
// reset to 0 and scales to 256. Configuration is written through cfg_we /
// cfg_index / cfg_wdata; the user must do so while the block is idle (not enforced).
// When the receiver stalls, the output holds; the pipe keeps filling its
// empty stages, and in_stall rises only once a result would have nowhere
// to go.

module simcc_keypoint_argmax_decoder
	import sakd_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [CFG_DATA_W-1:0]     cfg_wdata,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      cmd,
	input  wire logic signed [VAL_W-1:0]   sample,
	input  wire logic                      row_end,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [KP_W-1:0]                keypoint_number,
	output logic [COORD_W-1:0]             coord_x,
	output logic [COORD_W-1:0]             coord_y,
	output logic signed [SCORE_W-1:0]      score,
	output logic                           last_keypoint
);

	logic signed [ZP_W-1:0] zp_x_q, zp_y_q;
	logic [SCALE_W-1:0]     scale_x_q, scale_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zp_x_q    <= '0;
			zp_y_q    <= '0;
			scale_x_q <= SCALE_RESET;
			scale_y_q <= SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ZERO_POINT_X: zp_x_q    <= cfg_wdata[ZP_W-1:0];
				CFG_ZERO_POINT_Y: zp_y_q    <= cfg_wdata[ZP_W-1:0];
				CFG_SCALE_X:      scale_x_q <= cfg_wdata[SCALE_W-1:0];
				CFG_SCALE_Y:      scale_y_q <= cfg_wdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// ready chain, output register back to the input
	logic s1_valid, s2_valid, out_valid_q;
	logic rdy_out, rdy_s2, rdy_s1;

	assign rdy_out  = !out_valid_q || !out_stall;
	assign rdy_s2   = !s2_valid || rdy_out;
	assign rdy_s1   = !s1_valid || rdy_s2;
	assign in_stall = !rdy_s1;

	logic    accept, emit;
	kp_res_t res;

	assign accept = in_valid && !in_stall;

	sakd_row_tracker u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.cmd     (cmd),
		.sample  (sample),
		.row_end (row_end),
		.emit    (emit),
		.res     (res)
	);

	// stage 1: finished argmax of both rows
	kp_res_t s1_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (rdy_s1) begin
			s1_valid <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && accept && emit) begin
			s1_res <= res;
		end
	end

	// stage 2: dequantize both maxima
	logic signed [DIFF_W-1:0] diff_x, diff_y;
	logic signed [PROD_W-1:0] prod_x, prod_y;

	always_comb begin
		diff_x = $signed({s1_res.val_x[VAL_W-1], s1_res.val_x})
			- $signed({zp_x_q[ZP_W-1], zp_x_q});
		diff_y = $signed({s1_res.val_y[VAL_W-1], s1_res.val_y})
			- $signed({zp_y_q[ZP_W-1], zp_y_q});
		prod_x = diff_x * $signed({1'b0, scale_x_q});
		prod_y = diff_y * $signed({1'b0, scale_y_q});
	end

	logic signed [SCORE_W-1:0] prod_x_s2, prod_y_s2;
	logic [KP_W-1:0]           kp_s2;
	logic                      last_s2;
	logic [COORD_W-1:0]        cx_s2, cy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (rdy_s2) begin
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && s1_valid) begin
			prod_x_s2 <= prod_x[SCORE_W-1:0];
			prod_y_s2 <= prod_y[SCORE_W-1:0];
			kp_s2     <= s1_res.kp;
			last_s2   <= s1_res.last;
			cx_s2     <= COORD_W'(s1_res.idx_x >> 1);
			cy_s2     <= COORD_W'(s1_res.idx_y >> 1);
		end
	end

	// output register: pick the larger score
	logic signed [SCORE_W-1:0] score_q;
	logic [KP_W-1:0]           kp_q;
	logic                      last_q;
	logic [COORD_W-1:0]        cx_q, cy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && s2_valid) begin
			score_q <= (prod_x_s2 > prod_y_s2) ? prod_x_s2 : prod_y_s2;
			kp_q    <= kp_s2;
			last_q  <= last_s2;
			cx_q    <= cx_s2;
			cy_q    <= cy_s2;
		end
	end

	assign out_valid       = out_valid_q;
	assign keypoint_number = kp_q;
	assign coord_x         = cx_q;
	assign coord_y         = cy_q;
	assign score           = score_q;
	assign last_keypoint   = last_q;

endmodule

`default_nettype wire

/* design/sakd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module sakd_checker
	import sakd_pkg::*;
(
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      out_valid,
	input wire logic                      out_stall,
	input wire logic [KP_W-1:0]           keypoint_number,
	input wire logic signed [SCORE_W-1:0] score,
	input wire logic                      last_keypoint
);

	localparam logic signed [SCORE_W-1:0] SCORE_MAX = SCORE_W'(16711425);
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = -SCORE_MAX;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(score))
		else $error("stalled output beat dropped or changed");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_keypoint == (keypoint_number == KP_LAST)))
		else $error("last_keypoint disagrees with keypoint_number");

	a_kp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> keypoint_number <= KP_LAST)
		else $error("keypoint_number beyond keypoint count");

	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (score >= SCORE_MIN) && (score <= SCORE_MAX))
		else $error("score outside dequantized range");

endmodule

bind simcc_keypoint_argmax_decoder sakd_checker u_sakd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.keypoint_number (keypoint_number),
	.score           (score),
	.last_keypoint   (last_keypoint)
);

`default_nettype wire
